// File: hw/rtl/sllm_pkg.sv
// shared types and codes for the singly linked list manager
// no dependencies; imported by the channel users, control and top level
package sllm_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountOutW = 7;

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_REM_HEAD  = 2'd1,
    OP_REM_TAIL  = 2'd2,
    OP_REM_AFTER = 2'd3
  } sllm_op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_SUCC   = 3'd3,
    ST_FULL      = 3'd4
  } sllm_status_e;

  typedef struct packed {
    sllm_op_e                  operation;
    logic signed [ValueW-1:0]  value;
  } sllm_req_t;

  typedef struct packed {
    sllm_status_e              status;
    logic signed [ValueW-1:0]  removed_value;
    logic [CountOutW-1:0]      entry_count;
  } sllm_rsp_t;

  // enables from the sequencer to the node store
  typedef struct packed {
    logic rd_en;
    logic val_we;
    logic lnk_we;
  } sllm_mem_ctl_t;

endpackage

// File: hw/rtl/sllm_chan_if.sv
// valid/ready channel carrying one payload beat
// payload type is set by whoever instantiates it (sllm_req_t or sllm_rsp_t)
interface sllm_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/singly_linked_list_manager_unit.sv
// Singly linked list manager: ordered list of signed 32-bit values in a node store.
// Request channel req_i (sllm_req_t: operation, value), response channel rsp_o
// (sllm_rsp_t: status, removed_value, entry_count); one response beat per request.
// Operations: append at tail, remove head, remove tail, remove successor of the
// first node whose value matches.
// One item at a time. Remove tail on n >= 2 nodes walks n-2 links from the head
// to the node before the tail, one link read a cycle; remove-after walks from the
// head to the first match or the end of the list, then reads and unlinks the
// successor of the match if there is one.
// The walk speed is set by the single read port of the node store.
// The result sits in an output register; the next request is taken while it
// waits, and a stalled receiver only holds the following result back.
// Reset clears head, tail, count and the free-slot stack; the node memories
// need no clearing, so the block takes requests right after reset.
// Depends on sllm_pkg, sllm_chan_if, sllm_ctrl and sllm_store.
module singly_linked_list_manager_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sllm_chan_if.sink   req_i,
  sllm_chan_if.source rsp_o
);
  import sllm_pkg::*;

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  sllm_mem_ctl_t     mem_ctl;
  logic [SW-1:0]     rd_addr;
  logic [SW-1:0]     val_waddr;
  logic [ValueW-1:0] val_wdata;
  logic [SW-1:0]     lnk_waddr;
  logic [SW-1:0]     lnk_wdata;
  logic [ValueW-1:0] val_rd;
  logic [SW-1:0]     lnk_rd;

  sllm_ctrl #(
    .CAPACITY (CAPACITY),
    .SW       (SW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ctl_o       (mem_ctl),
    .rd_addr_o   (rd_addr),
    .val_waddr_o (val_waddr),
    .val_wdata_o (val_wdata),
    .lnk_waddr_o (lnk_waddr),
    .lnk_wdata_o (lnk_wdata),
    .val_rd_i    (val_rd),
    .lnk_rd_i    (lnk_rd)
  );

  sllm_store #(
    .CAPACITY (CAPACITY),
    .SW       (SW)
  ) u_store (
    .clk_i       (clk_i),
    .ctl_i       (mem_ctl),
    .rd_addr_i   (rd_addr),
    .val_waddr_i (val_waddr),
    .val_wdata_i (val_wdata),
    .lnk_waddr_i (lnk_waddr),
    .lnk_wdata_i (lnk_wdata),
    .val_rd_o    (val_rd),
    .lnk_rd_o    (lnk_rd)
  );

endmodule

// File: hw/rtl/sllm_store.sv
// node store: value and link memories, one read address, registered read data
// depends on sllm_pkg for the control struct
module sllm_store #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned SW       = $clog2(CAPACITY)
) (
  input  logic                        clk_i,
  input  sllm_pkg::sllm_mem_ctl_t     ctl_i,
  input  logic [SW-1:0]               rd_addr_i,
  input  logic [SW-1:0]               val_waddr_i,
  input  logic [sllm_pkg::ValueW-1:0] val_wdata_i,
  input  logic [SW-1:0]               lnk_waddr_i,
  input  logic [SW-1:0]               lnk_wdata_i,
  output logic [sllm_pkg::ValueW-1:0] val_rd_o,
  output logic [SW-1:0]               lnk_rd_o
);
  import sllm_pkg::*;

  logic [ValueW-1:0] val_mem [CAPACITY];
  logic [SW-1:0]     lnk_mem [CAPACITY];
  logic [ValueW-1:0] val_rd_q;
  logic [SW-1:0]     lnk_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.val_we) begin
      val_mem[val_waddr_i] <= val_wdata_i;
    end
    if (ctl_i.lnk_we) begin
      lnk_mem[lnk_waddr_i] <= lnk_wdata_i;
    end
    if (ctl_i.rd_en) begin
      val_rd_q <= val_mem[rd_addr_i];
      lnk_rd_q <= lnk_mem[rd_addr_i];
    end
  end

  assign val_rd_o = val_rd_q;
  assign lnk_rd_o = lnk_rd_q;

endmodule

// File: hw/rtl/sllm_ctrl.sv
// list sequencer: head/tail/count, free stack, walks and the result register
// depends on sllm_pkg, sllm_chan_if; drives the ports of sllm_store
module sllm_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned SW       = $clog2(CAPACITY),
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sllm_chan_if.sink                   req_i,
  sllm_chan_if.source                 rsp_o,
  output sllm_pkg::sllm_mem_ctl_t     ctl_o,
  output logic [SW-1:0]               rd_addr_o,
  output logic [SW-1:0]               val_waddr_o,
  output logic [sllm_pkg::ValueW-1:0] val_wdata_o,
  output logic [SW-1:0]               lnk_waddr_o,
  output logic [SW-1:0]               lnk_wdata_o,
  input  logic [sllm_pkg::ValueW-1:0] val_rd_i,
  input  logic [SW-1:0]               lnk_rd_i
);
  import sllm_pkg::*;

  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [CW-1:0] OneC = CW'(1);
  localparam logic [CW-1:0] TwoC = CW'(2);

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_HEAD_RD,
    S_TAIL_RD,
    S_TAIL_WALK,
    S_TAIL_FIN,
    S_MATCH_WALK,
    S_VICTIM_RD,
    S_VICTIM_FIX,
    S_RESP
  } state_e;

  state_e            state_q;
  sllm_op_e          in_op;
  logic [ValueW-1:0] in_val;
  logic [ValueW-1:0] val_q;
  logic [SW-1:0]     head_q, tail_q, ftop_q, p_q, victim_q, slot_q;
  logic [CW-1:0]     cnt_q, wm_q, rem_q, pos_q;
  logic              pop_q;
  logic [ValueW-1:0] removed_q;
  sllm_status_e      status_q;
  logic              rsp_valid_q;
  sllm_rsp_t         rsp_q;
  logic              accept;
  logic              match;
  logic              cnt_full;
  logic              stack_nonempty;
  logic [CW-1:0]     cnt_m2;
  logic [CW+CountOutW-1:0] cnt_ext;

  assign in_op          = req_i.data.operation;
  assign in_val         = req_i.data.value;
  assign req_i.ready    = (state_q == S_IDLE);
  assign accept         = req_i.valid && req_i.ready;
  assign match          = (val_rd_i == val_q);
  assign cnt_full       = (cnt_q == CapC);
  assign stack_nonempty = (cnt_q < wm_q);
  assign cnt_m2         = cnt_q - TwoC;
  assign cnt_ext        = {{CountOutW{1'b0}}, cnt_q};

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // memory port drive
  always_comb begin
    ctl_o       = '0;
    rd_addr_o   = '0;
    val_waddr_o = slot_q;
    val_wdata_o = val_q;
    lnk_waddr_o = '0;
    lnk_wdata_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_APPEND: begin
              if (!cnt_full && stack_nonempty) begin
                ctl_o.rd_en = 1'b1;
                rd_addr_o   = ftop_q;
              end
            end
            OP_REM_TAIL: begin
              ctl_o.rd_en = (cnt_q != '0);
              rd_addr_o   = tail_q;
            end
            default: begin
              ctl_o.rd_en = (cnt_q != '0);
              rd_addr_o   = head_q;
            end
          endcase
        end
      end
      S_APPEND: begin
        ctl_o.val_we = 1'b1;
        ctl_o.lnk_we = (cnt_q != '0);
        lnk_waddr_o  = tail_q;
        lnk_wdata_o  = slot_q;
      end
      S_HEAD_RD: begin
        ctl_o.lnk_we = 1'b1;
        lnk_waddr_o  = head_q;
        lnk_wdata_o  = ftop_q;
      end
      S_TAIL_RD: begin
        ctl_o.rd_en = (cnt_q > OneC) && (cnt_m2 != '0);
        rd_addr_o   = head_q;
      end
      S_TAIL_WALK: begin
        ctl_o.rd_en = (rem_q != OneC);
        rd_addr_o   = lnk_rd_i;
      end
      S_TAIL_FIN: begin
        ctl_o.lnk_we = 1'b1;
        lnk_waddr_o  = tail_q;
        lnk_wdata_o  = ftop_q;
      end
      S_MATCH_WALK: begin
        // either the successor of a match or the next node to compare
        ctl_o.rd_en = (pos_q < cnt_q);
        rd_addr_o   = lnk_rd_i;
      end
      S_VICTIM_RD: begin
        ctl_o.lnk_we = 1'b1;
        lnk_waddr_o  = p_q;
        lnk_wdata_o  = lnk_rd_i;
      end
      S_VICTIM_FIX: begin
        ctl_o.lnk_we = 1'b1;
        lnk_waddr_o  = victim_q;
        lnk_wdata_o  = ftop_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      ftop_q      <= '0;
      cnt_q       <= '0;
      wm_q        <= '0;
      rsp_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      // in S_RESP a leaving beat is replaced by the new one below
      if (rsp_o.valid && rsp_o.ready && (state_q != S_RESP)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            val_q     <= in_val;
            removed_q <= '0;
            status_q  <= ST_OK;
            if (in_op == OP_APPEND) begin
              if (cnt_full) begin
                status_q <= ST_FULL;
                state_q  <= S_RESP;
              end else begin
                pop_q   <= stack_nonempty;
                slot_q  <= stack_nonempty ? ftop_q : wm_q[SW-1:0];
                state_q <= S_APPEND;
              end
            end else if (cnt_q == '0) begin
              status_q <= ST_EMPTY;
              state_q  <= S_RESP;
            end else begin
              unique case (in_op)
                OP_REM_HEAD: state_q <= S_HEAD_RD;
                OP_REM_TAIL: state_q <= S_TAIL_RD;
                default: begin
                  p_q     <= head_q;
                  pos_q   <= OneC;
                  state_q <= S_MATCH_WALK;
                end
              endcase
            end
          end
        end
        S_APPEND: begin
          if (pop_q) begin
            ftop_q <= lnk_rd_i;
          end else begin
            wm_q <= wm_q + OneC;
          end
          if (cnt_q == '0) begin
            head_q <= slot_q;
          end
          tail_q  <= slot_q;
          cnt_q   <= cnt_q + OneC;
          state_q <= S_RESP;
        end
        S_HEAD_RD: begin
          removed_q <= val_rd_i;
          ftop_q    <= head_q;
          cnt_q     <= cnt_q - OneC;
          if (cnt_q == OneC) begin
            head_q <= '0;
            tail_q <= '0;
          end else begin
            head_q <= lnk_rd_i;
          end
          state_q <= S_RESP;
        end
        S_TAIL_RD: begin
          removed_q <= val_rd_i;
          p_q       <= head_q;
          rem_q     <= cnt_m2;
          if (cnt_q > OneC && cnt_m2 != '0) begin
            state_q <= S_TAIL_WALK;
          end else begin
            state_q <= S_TAIL_FIN;
          end
        end
        S_TAIL_WALK: begin
          p_q   <= lnk_rd_i;
          rem_q <= rem_q - OneC;
          if (rem_q == OneC) begin
            state_q <= S_TAIL_FIN;
          end
        end
        S_TAIL_FIN: begin
          ftop_q <= tail_q;
          cnt_q  <= cnt_q - OneC;
          if (cnt_q == OneC) begin
            head_q <= '0;
            tail_q <= '0;
          end else begin
            tail_q <= p_q;
          end
          state_q <= S_RESP;
        end
        S_MATCH_WALK: begin
          if (match) begin
            if (pos_q >= cnt_q) begin
              status_q <= ST_NO_SUCC;
              state_q  <= S_RESP;
            end else begin
              victim_q <= lnk_rd_i;
              state_q  <= S_VICTIM_RD;
            end
          end else if (pos_q >= cnt_q) begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_RESP;
          end else begin
            p_q   <= lnk_rd_i;
            pos_q <= pos_q + OneC;
          end
        end
        S_VICTIM_RD: begin
          removed_q <= val_rd_i;
          // victim was the tail: the matching node takes its place
          if (pos_q + OneC == cnt_q) begin
            tail_q <= p_q;
          end
          state_q <= S_VICTIM_FIX;
        end
        S_VICTIM_FIX: begin
          ftop_q  <= victim_q;
          cnt_q   <= cnt_q - OneC;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q         <= 1'b1;
            rsp_q.status        <= status_q;
            rsp_q.removed_value <= removed_q;
            rsp_q.entry_count   <= cnt_ext[CountOutW-1:0];
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/tb_singly_linked_list_manager_unit.sv
// testbench for singly_linked_list_manager_unit: directed and random list operations
// checked beat by beat against a value-queue mirror of the list held in a scoreboard
// depends on sllm_pkg, sllm_chan_if and the unit itself
module tb_singly_linked_list_manager_unit;
  import sllm_pkg::*;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned DRAIN_CYCLES = 80;

  // mirror of the list as an ordered queue of values, head first
  class list_scoreboard;
    int unsigned capacity;
    logic signed [ValueW-1:0] contents[$];
    sllm_rsp_t due_rsps[$];
    int unsigned errors;

    function new(int unsigned cap);
      capacity = cap;
      errors = 0;
    endfunction

    function int unsigned pending();
      return due_rsps.size();
    endfunction

    // apply one accepted request to the mirror and queue its response
    function void note_request(sllm_req_t r);
      sllm_rsp_t e;
      int hit;
      e.status = ST_OK;
      e.removed_value = '0;
      hit = -1;
      if (r.operation == OP_APPEND) begin
        if (contents.size() >= capacity) e.status = ST_FULL;
        else contents.push_back(r.value);
      end else if (contents.size() == 0) begin
        e.status = ST_EMPTY;
      end else begin
        case (r.operation)
          OP_REM_HEAD: e.removed_value = contents.pop_front();
          OP_REM_TAIL: e.removed_value = contents.pop_back();
          default: begin
            foreach (contents[i])
              if (hit < 0 && contents[i] == r.value) hit = i;
            if (hit < 0) begin
              e.status = ST_NOT_FOUND;
            end else if (hit == contents.size() - 1) begin
              e.status = ST_NO_SUCC;
            end else begin
              e.removed_value = contents[hit+1];
              contents.delete(hit + 1);
            end
          end
        endcase
      end
      e.entry_count = CountOutW'(contents.size());
      due_rsps.push_back(e);
    endfunction

    function void check_response(sllm_rsp_t got);
      sllm_rsp_t exp;
      if (due_rsps.size() == 0) begin
        $display("%0t: unexpected response beat, got status %0d value %0d count %0d",
                 $time, got.status, got.removed_value, got.entry_count);
        errors++;
        return;
      end
      exp = due_rsps.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.removed_value !== exp.removed_value) begin
        $display("%0t: removed value mismatch, expected %0d, got %0d",
                 $time, exp.removed_value, got.removed_value);
        errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $display("%0t: entry count mismatch, expected %0d, got %0d",
                 $time, exp.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit calm = 1'b0;
  bit long_hold_done = 1'b0;
  int unsigned stall_left = 0;
  int unsigned responses_seen = 0;
  int unsigned quiet_cycles = 0;
  list_scoreboard sb = new(SLOTS);

  sllm_chan_if #(.T(sllm_req_t)) req_if ();
  sllm_chan_if #(.T(sllm_rsp_t)) rsp_if ();

  singly_linked_list_manager_unit #(
    .CAPACITY(SLOTS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // small values repeat often so that matches and duplicates show up
  function automatic logic signed [ValueW-1:0] any_value();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom_range(0, 15) - 8;
      4, 5: return $urandom();
      6: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom_range(0, 1) ? 32'sh0000_0000 : 32'shFFFF_FFFF;
    endcase
  endfunction

  function automatic logic signed [ValueW-1:0] match_value();
    if (sb.contents.size() != 0 && $urandom_range(0, 9) < 7)
      return sb.contents[$urandom_range(0, sb.contents.size() - 1)];
    return any_value();
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic offer(sllm_op_e op, logic signed [ValueW-1:0] v);
    sllm_req_t r;
    r.operation = op;
    r.value = v;
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic random_run(int unsigned n, int unsigned grow_pct);
    sllm_op_e op;
    repeat (n) begin
      if ($urandom_range(0, 99) < grow_pct) op = OP_APPEND;
      else op = sllm_op_e'($urandom_range(OP_REM_HEAD, OP_REM_AFTER));
      offer(op, (op == OP_REM_AFTER) ? match_value() : any_value());
    end
  endtask

  // receiver: short random stalls, one long hold-off early on, none at the end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && responses_seen >= 60) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end else begin
      rsp_if.ready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) begin
      sb.check_response(rsp_if.data);
      responses_seen++;
    end
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // removals on an empty list
    offer(OP_REM_HEAD, 32'sd0);
    offer(OP_REM_TAIL, 32'shFFFF_FFFF);
    offer(OP_REM_AFTER, 32'sd0);
    // extremes, then remove-after: no match, on the tail, middle, moving the tail
    offer(OP_APPEND, 32'sh8000_0000);
    offer(OP_APPEND, 32'sh7FFF_FFFF);
    offer(OP_APPEND, 32'sd0);
    offer(OP_APPEND, 32'shFFFF_FFFF);
    offer(OP_REM_AFTER, 32'sd12345);
    offer(OP_REM_AFTER, 32'shFFFF_FFFF);
    offer(OP_REM_AFTER, 32'sh8000_0000);
    offer(OP_REM_AFTER, 32'sd0);
    offer(OP_APPEND, 32'sd5);
    // remove-tail walks, down to the last node
    offer(OP_REM_TAIL, 32'sh5555_5555);
    offer(OP_REM_TAIL, 32'shAAAA_AAAA);
    offer(OP_REM_TAIL, 32'sd0);
    // duplicates: the first match wins
    offer(OP_APPEND, 32'sd3);
    offer(OP_APPEND, 32'sd3);
    offer(OP_APPEND, 32'sd9);
    offer(OP_REM_AFTER, 32'sd3);
    offer(OP_REM_HEAD, 32'sd0);
    offer(OP_REM_HEAD, 32'sd0);
    // single node after the list emptied
    offer(OP_APPEND, 32'sd4);
    offer(OP_REM_AFTER, 32'sd4);
    offer(OP_REM_HEAD, 32'sd0);

    random_run(80, 50);
    // hold the sender until every response is back
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    random_run(70, 100);
    random_run(40, 30);
    random_run(90, 20);
    random_run(80, 55);
    calm = 1'b1;
    random_run(70, 50);
    req_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
